// ----- hw/rtl/tfhl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfhl_pkg
// Shared constants and types of the thermal frame hotspot locator.
// ----------------------------------------------------------------------------
package tfhl_pkg;

    localparam int FRAME_COLS = 32;
    localparam int FRAME_ROWS = 24;
    localparam int FRAME_SIZE = FRAME_COLS * FRAME_ROWS;
    localparam int FRAME_DIM  = (FRAME_COLS > FRAME_ROWS) ? FRAME_COLS : FRAME_ROWS;

    // port field widths
    localparam int PIXEL_W  = 8;
    localparam int CENTER_W = 5;
    localparam int COUNT_W  = 10;

    // internal widths
    localparam int COL_W  = $clog2(FRAME_COLS);
    localparam int ROW_W  = $clog2(FRAME_ROWS);
    localparam int QUOT_W = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int TIE_W  = $clog2(FRAME_SIZE + 1);
    localparam int SUM_W  = $clog2(FRAME_SIZE * (FRAME_DIM - 1) + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COL_START,
        ST_DIV_COL,
        ST_DIV_ROW,
        ST_FINISH
    } tfhl_state_t;

endpackage

// ----- hw/rtl/tfhl_pixel_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfhl_pixel_if
// Pixel stream channel: valid/ready with pixel value and frame end mark.
// ----------------------------------------------------------------------------
interface tfhl_pixel_if;
    import tfhl_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_value;
    logic               frame_end;

    modport source (output valid, output pixel_value, output frame_end, input ready);
    modport sink   (input valid, input pixel_value, input frame_end, output ready);
endinterface

// ----- hw/rtl/tfhl_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfhl_result_if
// Result channel: valid/ready with peak value, tie centroid and tie count.
// ----------------------------------------------------------------------------
interface tfhl_result_if;
    import tfhl_pkg::*;

    logic                valid;
    logic                ready;
    logic [PIXEL_W-1:0]  peak_value;
    logic [CENTER_W-1:0] center_col;
    logic [CENTER_W-1:0] center_row;
    logic [COUNT_W-1:0]  peak_count;

    modport source (
        output valid, output peak_value, output center_col, output center_row,
        output peak_count, input ready
    );
    modport sink (
        input valid, input peak_value, input center_col, input center_row,
        input peak_count, output ready
    );
endinterface

// ----- hw/rtl/tfhl_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfhl_divider
// Restoring divider, one quotient bit per cycle, for the tie centroid means.
// ----------------------------------------------------------------------------
module tfhl_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tfhl_pkg::SUM_W-1:0]  dividend,
    input  logic [tfhl_pkg::TIE_W-1:0]  divisor,
    output logic                        done,
    output logic [tfhl_pkg::QUOT_W-1:0] quotient
);
    import tfhl_pkg::*;

    localparam int DSH_W  = TIE_W + QUOT_W - 1;
    localparam int CMP_W  = (SUM_W > DSH_W) ? SUM_W : DSH_W;
    localparam int STEP_W = $clog2(QUOT_W + 1);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [DSH_W-1:0]  dsh_reg, dsh_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic              zero_reg, zero_next;

    logic [CMP_W-1:0]  rem_ext;
    logic [CMP_W-1:0]  dsh_ext;
    logic [CMP_W-1:0]  rem_diff;
    logic              fits;

    assign rem_ext  = CMP_W'(rem_reg);
    assign dsh_ext  = CMP_W'(dsh_reg);
    assign rem_diff = rem_ext - dsh_ext;
    assign fits     = (rem_ext >= dsh_ext);

    always_comb
    begin
        step_next = step_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        zero_next = zero_reg;
        if (start)
        begin
            step_next = STEP_W'(QUOT_W);
            rem_next  = dividend;
            dsh_next  = DSH_W'(divisor) << (QUOT_W - 1);
            quot_next = '0;
            zero_next = (divisor == '0);
        end
        else if (step_reg != '0)
        begin
            if (fits)
            begin
                rem_next = SUM_W'(rem_diff);
            end
            quot_next = QUOT_W'({quot_reg, fits});
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg - STEP_W'(1);
            done_next = (step_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
        zero_reg <= zero_next;
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? '0 : quot_reg;

endmodule

// ----- hw/rtl/thermal_frame_hotspot_locator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_frame_hotspot_locator_core
// Peak pixel value of a thermal frame with the mean position of its ties.
// ----------------------------------------------------------------------------
// Pixels of a 32 by 24 frame arrive in raster order, one transfer per cycle
// while the input is ready. After the pixel marked as frame end, the input
// is held off while one shared restoring divider produces the mean column
// and then the mean row: a start state, two divisions (one quotient bit per
// cycle for 5 bits, then a registered done flag) and a finish state that
// loads the result. The result sits in an output register, so pixels of the
// next frame are taken while it waits; if the next frame end arrives before
// that result has been taken, the input stays held off after the divisions
// until it is. Pixels beyond the frame size are ignored, but a frame end on
// them still closes the frame.
// ----------------------------------------------------------------------------
module thermal_frame_hotspot_locator_core (
    input  logic          clk,
    input  logic          rst_n,
    tfhl_pixel_if.sink    pixel,
    tfhl_result_if.source result
);
    import tfhl_pkg::*;

    tfhl_state_t state_reg, state_next;

    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               full_reg, full_next;
    logic [PIXEL_W-1:0] peak_reg, peak_next;
    logic [TIE_W-1:0]   tie_reg, tie_next;
    logic [SUM_W-1:0]   csum_reg, csum_next;
    logic [SUM_W-1:0]   rsum_reg, rsum_next;
    logic [QUOT_W-1:0]  cq_reg, cq_next;

    logic                out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0]  out_peak_reg, out_peak_next;
    logic [CENTER_W-1:0] out_col_reg, out_col_next;
    logic [CENTER_W-1:0] out_row_reg, out_row_next;
    logic [COUNT_W-1:0]  out_cnt_reg, out_cnt_next;

    logic              in_xfer;
    logic              first_pixel;
    logic              div_start;
    logic [SUM_W-1:0]  div_dividend;
    logic              div_done;
    logic [QUOT_W-1:0] div_quotient;

    tfhl_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (tie_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign pixel.ready = (state_reg == ST_IDLE);
    assign in_xfer     = pixel.valid && pixel.ready;
    assign first_pixel = (col_reg == '0) && (row_reg == '0) && !full_reg;

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        full_next      = full_reg;
        peak_next      = peak_reg;
        tie_next       = tie_reg;
        csum_next      = csum_reg;
        rsum_next      = rsum_reg;
        cq_next        = cq_reg;
        out_valid_next = out_valid_reg;
        out_peak_next  = out_peak_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_cnt_next   = out_cnt_reg;
        div_start      = 1'b0;
        div_dividend   = csum_reg;

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (!full_reg)
                    begin
                        if (first_pixel || (pixel.pixel_value > peak_reg))
                        begin
                            peak_next = pixel.pixel_value;
                            tie_next  = TIE_W'(1);
                            csum_next = SUM_W'(col_reg);
                            rsum_next = SUM_W'(row_reg);
                        end
                        else if (pixel.pixel_value == peak_reg)
                        begin
                            tie_next  = tie_reg + TIE_W'(1);
                            csum_next = csum_reg + SUM_W'(col_reg);
                            rsum_next = rsum_reg + SUM_W'(row_reg);
                        end
                        if (col_reg == COL_W'(FRAME_COLS - 1))
                        begin
                            col_next = '0;
                            if (row_reg == ROW_W'(FRAME_ROWS - 1))
                            begin
                                row_next  = '0;
                                full_next = 1'b1;
                            end
                            else
                            begin
                                row_next = row_reg + ROW_W'(1);
                            end
                        end
                        else
                        begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end
                    if (pixel.frame_end)
                    begin
                        state_next = ST_COL_START;
                    end
                end
            end
            ST_COL_START:
            begin
                div_start    = 1'b1;
                div_dividend = csum_reg;
                state_next   = ST_DIV_COL;
            end
            ST_DIV_COL:
            begin
                if (div_done)
                begin
                    cq_next      = div_quotient;
                    div_start    = 1'b1;
                    div_dividend = rsum_reg;
                    state_next   = ST_DIV_ROW;
                end
            end
            ST_DIV_ROW:
            begin
                if (div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_peak_next  = peak_reg;
                    out_col_next   = CENTER_W'(cq_reg);
                    out_row_next   = CENTER_W'(div_quotient);
                    out_cnt_next   = COUNT_W'(tie_reg);
                    col_next       = '0;
                    row_next       = '0;
                    full_next      = 1'b0;
                    peak_next      = '0;
                    tie_next       = '0;
                    csum_next      = '0;
                    rsum_next      = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            full_reg      <= 1'b0;
            peak_reg      <= '0;
            tie_reg       <= '0;
            csum_reg      <= '0;
            rsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            full_reg      <= full_next;
            peak_reg      <= peak_next;
            tie_reg       <= tie_next;
            csum_reg      <= csum_next;
            rsum_reg      <= rsum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cq_reg       <= cq_next;
        out_peak_reg <= out_peak_next;
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
        out_cnt_reg  <= out_cnt_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.peak_value = out_peak_reg;
    assign result.center_col = out_col_reg;
    assign result.center_row = out_row_reg;
    assign result.peak_count = out_cnt_reg;

endmodule

// ----- hw/rtl/tfhl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfhl_checker
// Port-level checks of the hotspot locator, bound to the top level.
// ----------------------------------------------------------------------------
module tfhl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          pixel_valid,
    input logic                          pixel_ready,
    input logic                          frame_end,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [tfhl_pkg::PIXEL_W-1:0]  peak_value,
    input logic [tfhl_pkg::CENTER_W-1:0] center_col,
    input logic [tfhl_pkg::CENTER_W-1:0] center_row,
    input logic [tfhl_pkg::COUNT_W-1:0]  peak_count
);
    import tfhl_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(peak_value)
        && $stable(center_col) && $stable(center_row) && $stable(peak_count))
    else $error("result changed while stalled");

    // frame end transfer starts the divide sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready && frame_end |=> !pixel_ready)
    else $error("pixel ready after frame end transfer");

    // a result always has at least one tied pixel within the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (peak_count != '0) && (peak_count <= COUNT_W'(FRAME_SIZE)))
    else $error("peak count out of range");

    // centroid stays inside the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (32'(center_col) < FRAME_COLS) && (32'(center_row) < FRAME_ROWS))
    else $error("centroid outside the frame");

endmodule

bind thermal_frame_hotspot_locator_core tfhl_checker u_tfhl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel.valid),
    .pixel_ready  (pixel.ready),
    .frame_end    (pixel.frame_end),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .peak_value   (result.peak_value),
    .center_col   (result.center_col),
    .center_row   (result.center_row),
    .peak_count   (result.peak_count)
);
